>>> hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // error codes carried with each result item
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_ESCAPE  = 2'd1,
        ERR_HEX     = 2'd2,
        ERR_EARLY   = 2'd3
    } t_err;

    localparam int unsigned HEX_DIGITS = 4;
    localparam int unsigned HEX_CNT_W  = 3;
    localparam int unsigned UNIT_W     = 16;

    // characters that the decoder looks for
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_N     = 8'h6e;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_U     = 8'h75;

    // control codes produced by the short escapes
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_HT = 8'h09;
    localparam logic [7:0] CODE_LF = 8'h0a;
    localparam logic [7:0] CODE_FF = 8'h0c;
    localparam logic [7:0] CODE_CR = 8'h0d;

    // decoder state kept between items
    typedef struct packed {
        logic                  escape_pending;
        logic [HEX_CNT_W-1:0]  hex_count;
        logic [UNIT_W-1:0]     hex_accum;
        logic                  wide_seen;
    } t_state;

    // one result item
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              unit_valid;
        logic              last;
        logic              wide;
        t_err              error_code;
    } t_result;

    // decoder outcome for one byte
    typedef struct packed {
        logic    emit;
        t_result res;
    } t_dec;

    // bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        return v;
    endfunction

endpackage

>>> hdl/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_byte_if / jsu_unit_if
// Valid/ready channels for string bytes in and decoded items out.
// ----------------------------------------------------------------------------
interface jsu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        last;
    logic        wide;
    logic [1:0]  error_code;

    modport source (output valid, output code_unit, output unit_valid,
                    output last, output wide, output error_code, input ready);
    modport sink   (input valid, input code_unit, input unit_valid,
                    input last, input wide, input error_code, output ready);
endinterface

>>> hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Per-byte escape decoder: next state and optional result from one byte.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic [7:0]      i_byte,
    input  jsu_pkg::t_state i_state,
    output jsu_pkg::t_state o_state,
    output jsu_pkg::t_dec   o_dec
);
    import jsu_pkg::*;

    logic [4:0]           hex_d;
    logic [UNIT_W-1:0]    acc;
    logic [HEX_CNT_W-1:0] cnt;
    t_state               nxt;
    t_dec                 dec;

    always_comb begin
        hex_d = hex_value(i_byte);
        acc   = {i_state.hex_accum[UNIT_W-5:0], hex_d[3:0]};
        cnt   = i_state.hex_count - HEX_CNT_W'(1);
        nxt   = i_state;
        dec   = '0;

        if (i_byte == CH_NUL) begin
            dec.emit           = 1'b1;
            dec.res.last       = 1'b1;
            dec.res.error_code = ERR_EARLY;
        end else if (i_state.hex_count != '0) begin
            if (hex_d[4]) begin
                dec.emit           = 1'b1;
                dec.res.last       = 1'b1;
                dec.res.error_code = ERR_HEX;
            end else if (cnt == '0) begin
                nxt.hex_count = '0;
                nxt.hex_accum = '0;
                nxt.wide_seen = i_state.wide_seen | (acc[UNIT_W-1:8] != '0);
                dec.emit           = 1'b1;
                dec.res.code_unit  = acc;
                dec.res.unit_valid = 1'b1;
            end else begin
                nxt.hex_count = cnt;
                nxt.hex_accum = acc;
            end
        end else if (i_state.escape_pending) begin
            nxt.escape_pending = 1'b0;
            dec.emit           = 1'b1;
            dec.res.unit_valid = 1'b1;
            unique case (i_byte)
                CH_LOW_B:     dec.res.code_unit = UNIT_W'(CODE_BS);
                CH_LOW_T:     dec.res.code_unit = UNIT_W'(CODE_HT);
                CH_LOW_N:     dec.res.code_unit = UNIT_W'(CODE_LF);
                CH_LOW_F:     dec.res.code_unit = UNIT_W'(CODE_FF);
                CH_LOW_R:     dec.res.code_unit = UNIT_W'(CODE_CR);
                CH_QUOTE:     dec.res.code_unit = UNIT_W'(CH_QUOTE);
                CH_SLASH:     dec.res.code_unit = UNIT_W'(CH_SLASH);
                CH_BACKSLASH: dec.res.code_unit = UNIT_W'(CH_BACKSLASH);
                CH_LOW_U: begin
                    dec.emit           = 1'b0;
                    dec.res.unit_valid = 1'b0;
                    nxt.hex_count      = HEX_CNT_W'(HEX_DIGITS);
                    nxt.hex_accum      = '0;
                end
                default: begin
                    dec.res.unit_valid = 1'b0;
                    dec.res.last       = 1'b1;
                    dec.res.error_code = ERR_ESCAPE;
                end
            endcase
        end else if (i_byte == CH_QUOTE) begin
            dec.emit     = 1'b1;
            dec.res.last = 1'b1;
        end else if (i_byte == CH_BACKSLASH) begin
            nxt.escape_pending = 1'b1;
        end else begin
            dec.emit           = 1'b1;
            dec.res.code_unit  = UNIT_W'(i_byte);
            dec.res.unit_valid = 1'b1;
        end

        // wide flag reflects this result, then a finished string starts afresh
        dec.res.wide = nxt.wide_seen;
        if (dec.emit && dec.res.last) begin
            nxt = '0;
        end
    end

    assign o_state = nxt;
    assign o_dec   = dec;

endmodule

>>> hdl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for the body of a JSON string, taking one byte at a time.
// ----------------------------------------------------------------------------
// Feed the bytes that follow the opening quote, one per cycle. Plain bytes and
// completed escapes (\b \t \n \f \r \" \/ \\ and \u with exactly four hex
// digits) each give one 16-bit code unit. Backslashes, the u of \u and hex
// digits short of the fourth give no item. A closing quote, a bad escape, a bad
// hex digit or a zero byte gives one item with last set; wide says whether any
// unit of the string went above 0xff, and the decoder then starts a new string.
// The block takes one byte every cycle when the output is not stalled; a byte
// passes an input register, the decode logic and an output register, which
// presents its item until it is taken. Stalls at the output reach the input
// through the ready chain of the two registers.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jsu_byte_if.sink          i_byte,
    jsu_unit_if.source        o_unit
);
    import jsu_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // decoder state
    t_state     r_state;
    t_state     n_state;
    t_dec       dec;

    // output register
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;   // output register may load this cycle
    logic       adv;        // byte in the input register is consumed
    logic       in_take;    // new byte accepted

    jsu_decode u_decode (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_state (n_state),
        .o_dec   (dec)
    );

    assign out_free = !r_out_valid || o_unit.ready;
    // a byte that yields no item never waits for the output side
    assign adv      = r_in_valid && (!dec.emit || out_free);
    assign in_take  = i_byte.valid && i_byte.ready;

    assign i_byte.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            // input stage
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            // decoder state moves on with each consumed byte
            if (adv) begin
                r_state <= n_state;
            end
            // output stage
            if (adv && dec.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_unit.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte.in_byte;
        end
        if (adv && dec.emit) begin
            r_out <= dec.res;
        end
    end

    assign o_unit.valid      = r_out_valid;
    assign o_unit.code_unit  = r_out.code_unit;
    assign o_unit.unit_valid = r_out.unit_valid;
    assign o_unit.last       = r_out.last;
    assign o_unit.wide       = r_out.wide;
    assign o_unit.error_code = r_out.error_code;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a finishing item leaves the decoder in its start state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && dec.emit && dec.res.last) |=> (r_state == '0))
        else $error("state not cleared after last item");

    // an item never carries both a unit and an error
    a_unit_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.unit_valid && (r_out.error_code != ERR_NONE)))
        else $error("unit and error in one item");

    // never inside a hex escape and awaiting an escape letter at once
    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.escape_pending |-> (r_state.hex_count == '0))
        else $error("escape and hex modes overlap");

    // a stalled item is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_unit.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled item lost");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_string_unescape: drives string bodies with
// escapes, hex sequences and broken input, predicts every item and compares.
// ----------------------------------------------------------------------------
module tb;
    import jsu_pkg::*;

    localparam int N_BYTES     = 1700;
    localparam int HOLD_AT     = 400;  // results seen before the long output stall
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    logic i_clk;
    logic i_rst_n;

    jsu_byte_if byte_ch ();
    jsu_unit_if unit_ch ();

    json_string_unescape u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_unit  (unit_ch)
    );

    // value of a hex digit, or -1 when the byte is not one
    function automatic int hex_digit_of(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    // expected items for the decoder, with its own copy of the string state
    class unescape_scoreboard;
        logic        esc_pending;
        logic [2:0]  digits_left;
        logic [15:0] digit_acc;
        logic        wide_seen;
        t_result     expected_q[$];
        int          n_errors;
        int          n_results;

        function new();
            clear_string();
            n_errors  = 0;
            n_results = 0;
        endfunction

        function void clear_string();
            esc_pending = 1'b0;
            digits_left = '0;
            digit_acc   = '0;
            wide_seen   = 1'b0;
        endfunction

        function void push_unit(logic [15:0] unit, logic valid, logic last, t_err err);
            t_result r;
            r.code_unit  = unit;
            r.unit_valid = valid;
            r.last       = last;
            r.wide       = wide_seen;
            r.error_code = err;
            expected_q.insert(expected_q.size(), r);
            if (last) clear_string();
        endfunction

        // work out what one accepted byte should produce
        function void note_byte(logic [7:0] b);
            int d;
            if (b == CH_NUL) begin
                push_unit('0, 1'b0, 1'b1, ERR_EARLY);
                return;
            end
            if (digits_left != 0) begin
                d = hex_digit_of(b);
                if (d < 0) begin
                    push_unit('0, 1'b0, 1'b1, ERR_HEX);
                    return;
                end
                digit_acc   = {digit_acc[11:0], 4'(d)};
                digits_left = digits_left - 3'd1;
                if (digits_left == 0) begin
                    if (digit_acc[15:8] != 8'h00) wide_seen = 1'b1;
                    push_unit(digit_acc, 1'b1, 1'b0, ERR_NONE);
                    digit_acc = '0;
                end
                return;
            end
            if (esc_pending) begin
                esc_pending = 1'b0;
                case (b)
                    CH_LOW_B:     push_unit({8'h00, CODE_BS}, 1'b1, 1'b0, ERR_NONE);
                    CH_LOW_T:     push_unit({8'h00, CODE_HT}, 1'b1, 1'b0, ERR_NONE);
                    CH_LOW_N:     push_unit({8'h00, CODE_LF}, 1'b1, 1'b0, ERR_NONE);
                    CH_LOW_F:     push_unit({8'h00, CODE_FF}, 1'b1, 1'b0, ERR_NONE);
                    CH_LOW_R:     push_unit({8'h00, CODE_CR}, 1'b1, 1'b0, ERR_NONE);
                    CH_QUOTE, CH_SLASH, CH_BACKSLASH:
                                  push_unit({8'h00, b}, 1'b1, 1'b0, ERR_NONE);
                    CH_LOW_U: begin
                        digits_left = 3'(HEX_DIGITS);
                        digit_acc   = '0;
                    end
                    default:      push_unit('0, 1'b0, 1'b1, ERR_ESCAPE);
                endcase
                return;
            end
            if (b == CH_QUOTE) begin
                push_unit('0, 1'b0, 1'b1, ERR_NONE);
            end else if (b == CH_BACKSLASH) begin
                esc_pending = 1'b1;
            end else begin
                push_unit({8'h00, b}, 1'b1, 1'b0, ERR_NONE);
            end
        endfunction

        function void report(string what, t_result want, t_result got);
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("%0t: %s: expected unit %h valid %b last %b wide %b err %0d",
                         $realtime, what, want.code_unit, want.unit_valid, want.last,
                         want.wide, want.error_code);
                $display("    got unit %h valid %b last %b wide %b err %0d",
                         got.code_unit, got.unit_valid, got.last, got.wide,
                         got.error_code);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (expected_q.size() == 0) begin
                want = '0;
                report("item with nothing expected", want, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.code_unit  !== want.code_unit  || got.unit_valid !== want.unit_valid ||
                got.last       !== want.last       || got.wide       !== want.wide       ||
                got.error_code !== want.error_code) begin
                report("mismatch", want, got);
            end
        endfunction

        function void check_drained();
            t_result none;
            none = '0;
            while (expected_q.size() != 0) begin
                report("item never arrived", expected_q.pop_front(), none);
            end
        endfunction
    endclass

    unescape_scoreboard sb;
    int n_sent;
    int n_recv_draws;

    // clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard limit on the run
    initial begin
        #1_000_000;
        $display("FAIL json_string_unescape");
        $finish;
    end

    // gaps are random, with every fourth stretch of 80 left without idling
    function automatic int draw_gap(int n);
        if ((n / 80) % 4 == 1) return 0;
        return $urandom_range(0, 10);
    endfunction

    // offer one byte and wait for its handshake
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_gap(n_sent);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        sb.note_byte(b);
        n_sent++;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 10) return 8'("0") + 8'(n);
        return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    function automatic logic [7:0] rand_short_letter();
        logic [7:0] letters[8];
        letters = '{CH_LOW_B, CH_LOW_T, CH_LOW_N, CH_LOW_F, CH_LOW_R,
                    CH_QUOTE, CH_SLASH, CH_BACKSLASH};
        return letters[$urandom_range(0, 7)];
    endfunction

    // nonzero byte that no escape accepts
    function automatic logic [7:0] rand_bad_letter();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b inside {CH_LOW_B, CH_LOW_T, CH_LOW_N, CH_LOW_F, CH_LOW_R,
                         CH_QUOTE, CH_SLASH, CH_BACKSLASH, CH_LOW_U});
        return b;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (hex_digit_of(b) >= 0);
        return b;
    endfunction

    // \u and the leading n_digits hex digits of a value
    task automatic send_hex_prefix(logic [15:0] v, int n_digits);
        send_byte(CH_BACKSLASH);
        send_byte(CH_LOW_U);
        for (int i = 0; i < n_digits; i++) begin
            send_byte(hex_char(v[15 - 4*i -: 4], bit'($urandom_range(0, 1))));
        end
    endtask

    // one string body: mostly well formed, now and then cut short by a fault
    task automatic send_string();
        int n_elem;
        int r;
        logic [15:0] v;
        n_elem = $urandom_range(0, 10);
        for (int e = 0; e < n_elem; e++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_byte(rand_plain());
            end else if (r < 75) begin
                send_byte(CH_BACKSLASH);
                send_byte(rand_short_letter());
            end else if (r < 96) begin
                v = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 2) == 0) v[15:8] = 8'h00;
                send_hex_prefix(v, HEX_DIGITS);
            end else begin
                // faults end the string, so return straight after
                case ($urandom_range(0, 3))
                    0: begin
                        send_byte(CH_BACKSLASH);
                        send_byte(rand_bad_letter());
                    end
                    1: begin
                        send_hex_prefix(16'($urandom_range(0, 65535)), $urandom_range(0, 3));
                        send_byte(rand_non_hex());
                    end
                    2: begin
                        send_hex_prefix(16'($urandom_range(0, 65535)), $urandom_range(0, 3));
                        send_byte(CH_NUL);
                    end
                    default: begin
                        if ($urandom_range(0, 1)) send_byte(CH_BACKSLASH);
                        send_byte(CH_NUL);
                    end
                endcase
                return;
            end
        end
        if ($urandom_range(0, 9) == 0) send_byte(CH_NUL);
        else                           send_byte(CH_QUOTE);
    endtask

    // short stretch of arbitrary bytes, zero included
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
    endtask

    // output side: random stalls plus one long hold-off to back up the pipe
    initial begin : output_side
        int gap;
        bit held;
        t_result got;
        held = 1'b0;
        unit_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && sb.n_results >= HOLD_AT) begin
                held = 1'b1;
                unit_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = draw_gap(n_recv_draws);
                n_recv_draws++;
                if (gap > 0) begin
                    unit_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            unit_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!unit_ch.valid);
            got.code_unit  = unit_ch.code_unit;
            got.unit_valid = unit_ch.unit_valid;
            got.last       = unit_ch.last;
            got.wide       = unit_ch.wide;
            got.error_code = t_err'(unit_ch.error_code);
            sb.check_result(got);
        end
    end

    // reset, directed bytes, random strings and noise, then drain
    initial begin : input_side
        int wait_cycles;
        sb           = new();
        n_sent       = 0;
        n_recv_draws = 0;
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain extremes, two short escapes, a wide hex unit in mixed case, close
        send_byte(8'h01);
        send_byte(8'hff);
        send_byte(CH_BACKSLASH);
        send_byte(CH_LOW_N);
        send_byte(CH_BACKSLASH);
        send_byte(CH_QUOTE);
        send_byte(CH_BACKSLASH);
        send_byte(CH_LOW_U);
        send_byte("F");
        send_byte("f");
        send_byte("0");
        send_byte("9");
        send_byte(CH_QUOTE);
        // unknown escape letter
        send_byte(CH_BACKSLASH);
        send_byte("x");
        // non-hex byte inside a hex escape
        send_byte(CH_BACKSLASH);
        send_byte(CH_LOW_U);
        send_byte("g");
        // zero byte as a plain byte, after a backslash and inside a hex escape
        send_byte(CH_NUL);
        send_byte(CH_BACKSLASH);
        send_byte(CH_NUL);
        send_byte(CH_BACKSLASH);
        send_byte(CH_LOW_U);
        send_byte("a");
        send_byte(CH_NUL);

        while (n_sent < N_BYTES) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            else                            send_string();
        end
        byte_ch.valid <= 1'b0;

        // wait for the last items, bounded
        wait_cycles = 0;
        while (sb.expected_q.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        sb.check_drained();

        if (sb.n_errors == 0) begin
            $display("PASS json_string_unescape");
        end else begin
            $display("FAIL json_string_unescape");
        end
        $finish;
    end

endmodule
